>>> src/qhtk_pkg.sv
// Shared types and constants for the 4-ary top-k heap block.
package qhtk_pkg;

  localparam int KEY_W  = 32;
  localparam int VAL_W  = 31;
  localparam int CNT_W  = 7;
  localparam int RIDX_W = 6;
  localparam int OP_W   = 2;
  localparam int IN_W   = 72;
  localparam int OUT_W  = 104;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_LAST,
    S_DECIDE,
    S_READ,
    S_FINISH
  } state_t;

  // control into the best-child compare unit
  typedef struct packed {
    logic load;   // first child of a node: take unconditionally
    logic upd;    // read data valid this cycle
  } best_ctl_t;

endpackage

>>> src/quad_heap_topk_fill_and_replace.sv
// Top-k selector: keeps the heap_size smallest (key, value) pairs in an ARITY-ary max-heap
// held in a RAM with one write port and one registered read port. One beat is taken at a
// time. Insert while filling writes slot heap_size-1-count and sifts down; once full, a
// key strictly below the root replaces it and sifts down. Each sift level sets up the
// children in S_CHECK, reads each child (up to ARITY) through the RAM read port in S_SCAN,
// finishes the compare in S_LAST and moves the larger child up in S_DECIDE; the last write
// and the result load end the operation. A beat can be taken while the previous result
// still waits on the output.
module quad_heap_topk_fill_and_replace import qhtk_pkg::*; #(
  parameter int MAX_HEAP = 64,
  parameter int ARITY    = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  // heap_size register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  // tdata: operation[1:0], key[33:2], value[64:34], read_index[70:65], zero[71]
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  // tdata: accepted[0], kept_count[7:1], worst_key[39:8], entry_key[71:40],
  //        entry_value[102:72], zero[103]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  localparam int AW  = $clog2(MAX_HEAP);
  localparam int ARW = $clog2(ARITY);
  // wide enough for child indices and for the slot count
  localparam int IW  = (AW + ARW + 1 > CNT_W + 1) ? AW + ARW + 1 : CNT_W + 1;
  localparam int CAP = (MAX_HEAP < 127) ? MAX_HEAP : 127;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] hsize_r;
  logic [CNT_W-1:0] fill_r;
  op_t              op_r;
  logic [KEY_W-1:0] item_key_r;
  logic [VAL_W-1:0] item_val_r;
  logic [RIDX_W-1:0] ridx_r;
  logic [AW-1:0]    s_r;
  logic [IW-1:0]    child_r;
  logic [IW-1:0]    last_r;
  logic             acc_r;
  logic             rd_pend_r;
  logic             rd_first_r;
  logic [AW-1:0]    rd_idx_r;
  logic [KEY_W-1:0] root_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  // effective size: zero means one, saturate at the storage depth
  logic [CNT_W-1:0] eff_n;
  logic [CNT_W-1:0] kept;
  logic             full;

  always_comb begin
    if (hsize_r == '0) begin
      eff_n = CNT_W'(1);
    end else if (hsize_r > CNT_W'(CAP)) begin
      eff_n = CNT_W'(CAP);
    end else begin
      eff_n = hsize_r;
    end
  end

  assign full = fill_r >= eff_n;
  assign kept = full ? eff_n : fill_r;

  // input beat fields
  op_t               in_op;
  logic [KEY_W-1:0]  in_key;
  logic [VAL_W-1:0]  in_val;
  logic [RIDX_W-1:0] in_ridx;
  logic              accept_in;
  logic [CNT_W-1:0]  ins_slot;
  logic              take_root;

  assign in_op     = op_t'(in_tdata[1:0]);
  assign in_key    = in_tdata[33:2];
  assign in_val    = in_tdata[64:34];
  assign in_ridx   = in_tdata[70:65];
  // no beat is taken while reset is applied
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign accept_in = in_tvalid && in_tready;
  assign ins_slot  = eff_n - CNT_W'(1) - fill_r;
  assign take_root = in_key < root_r;

  assign cfg_ready = rst_n;

  // children of the current slot
  logic [IW-1:0] n_ext, first_c, rem_c, cnt_c, last_c;
  logic          has_kids;

  assign n_ext    = IW'(eff_n);
  assign first_c  = IW'(ARITY) * IW'(s_r) + IW'(1);
  assign has_kids = first_c < n_ext;
  assign rem_c    = n_ext - first_c;
  assign cnt_c    = (rem_c > IW'(ARITY)) ? IW'(ARITY) : rem_c;
  assign last_c   = first_c + cnt_c - IW'(1);

  // RAM and compare unit hookup
  logic                   wr_en, wr_best, rd_en;
  logic [AW-1:0]          rd_addr;
  logic [KEY_W+VAL_W-1:0] wr_data, rd_data;
  logic [KEY_W-1:0]       rd_key, best_key;
  logic [VAL_W-1:0]       rd_val, best_val;
  logic [AW-1:0]          best_idx;
  logic                   item_lt;
  best_ctl_t              best_ctl;
  logic                   out_free;

  assign rd_key   = rd_data[KEY_W-1:0];
  assign rd_val   = rd_data[KEY_W+VAL_W-1:KEY_W];
  assign wr_data  = wr_best ? {best_val, best_key} : {item_val_r, item_key_r};
  assign out_free = !out_valid_r || out_tready;

  // {load, upd}
  assign best_ctl = {rd_pend_r && rd_first_r, rd_pend_r};

  qhtk_mem #(.DEPTH(MAX_HEAP), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  qhtk_best #(.AW(AW)) u_best (
    .clk      (clk),
    .ctl      (best_ctl),
    .in_key   (rd_key),
    .in_val   (rd_val),
    .in_idx   (rd_idx_r),
    .item_key (item_key_r),
    .best_key (best_key),
    .best_val (best_val),
    .best_idx (best_idx),
    .item_lt  (item_lt)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept_in) begin
          unique case (in_op)
            OP_INSERT: state_nxt = (!full || take_root) ? S_CHECK : S_FINISH;
            OP_READ:   state_nxt = S_READ;
            OP_CLEAR:  state_nxt = S_FINISH;
            default:   state_nxt = S_FINISH;
          endcase
        end
      end
      S_CHECK:  state_nxt = has_kids ? S_SCAN : S_FINISH;
      S_SCAN:   state_nxt = (child_r == last_r) ? S_LAST : S_SCAN;
      S_LAST:   state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = item_lt ? S_CHECK : S_FINISH;
      S_READ:   state_nxt = S_FINISH;
      S_FINISH: state_nxt = out_free ? S_IDLE : S_FINISH;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    wr_en   = 1'b0;
    wr_best = 1'b0;
    rd_en   = 1'b0;
    rd_addr = AW'(child_r);
    unique case (state_r)
      S_CHECK: begin
        wr_en = !has_kids;   // leaf: item settles here
      end
      S_SCAN: begin
        rd_en = 1'b1;
      end
      S_DECIDE: begin
        wr_en   = 1'b1;
        wr_best = item_lt;   // larger child moves up, else item settles
      end
      S_READ: begin
        rd_en   = 1'b1;
        rd_addr = AW'(ridx_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hsize_r     <= CNT_W'(64);
      fill_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == S_SCAN);
      if (cfg_valid && cfg_ready) begin
        hsize_r <= cfg_data;
      end
      if (accept_in && in_op == OP_INSERT && !full) begin
        fill_r <= fill_r + CNT_W'(1);
      end else if (accept_in && in_op == OP_CLEAR) begin
        fill_r <= '0;
      end
      if (state_r == S_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  logic              hit;
  logic [CNT_W-1:0]  ridx_ext;
  logic [KEY_W-1:0]  entry_key, worst_key;
  logic [VAL_W-1:0]  entry_val;

  assign ridx_ext  = CNT_W'(ridx_r);
  assign hit       = (op_r == OP_READ) && (ridx_ext < eff_n) && (ridx_ext >= eff_n - kept);
  assign entry_key = hit ? rd_key : '0;
  assign entry_val = hit ? rd_val : '0;
  assign worst_key = full ? root_r : '0;

  always_ff @(posedge clk) begin
    if (accept_in) begin
      op_r       <= in_op;
      item_key_r <= in_key;
      item_val_r <= in_val;
      ridx_r     <= in_ridx;
      acc_r      <= (in_op == OP_INSERT) && (!full || take_root);
      if (in_op == OP_INSERT) begin
        if (!full) begin
          s_r <= AW'(ins_slot);
        end else if (take_root) begin
          s_r <= '0;
        end
      end
    end
    if (state_r == S_CHECK) begin
      child_r <= first_c;
      last_r  <= last_c;
    end
    if (state_r == S_SCAN) begin
      child_r    <= child_r + IW'(1);
      rd_first_r <= (child_r == first_c);
      rd_idx_r   <= AW'(child_r);
    end
    if (state_r == S_DECIDE && item_lt) begin
      s_r <= best_idx;
    end
    // shadow of slot 0 for the replace test and worst_key
    if (wr_en && s_r == '0) begin
      root_r <= wr_data[KEY_W-1:0];
    end
    if (state_r == S_FINISH && out_free) begin
      out_data_r <= {1'b0, entry_val, entry_key, worst_key, kept, acc_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // child reads only come back while a node is being scanned
  a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == S_SCAN || state_r == S_LAST))
    else $error("child read data outside a scan");

  // an insert into a filling heap bumps the count by one
  a_fill_bump: assert property (@(posedge clk) disable iff (!rst_n)
    (accept_in && in_op == OP_INSERT && !full) |=> fill_r == $past(fill_r) + CNT_W'(1))
    else $error("fill count did not advance on insert");

  // a sift step always moves strictly down the heap
  a_sift_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && item_lt) |-> best_idx > s_r)
    else $error("sift step did not move to a child");

endmodule

>>> src/qhtk_mem.sv
// Heap entry storage: one write port, one registered read port.
module qhtk_mem import qhtk_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [KEY_W+VAL_W-1:0] wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [KEY_W+VAL_W-1:0] rd_data
);

  logic [KEY_W+VAL_W-1:0] mem [DEPTH];
  logic [KEY_W+VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/qhtk_best.sv
// Shared compare unit: tracks the largest child and tests the sifting item against it.
module qhtk_best import qhtk_pkg::*; #(
  parameter int AW = 6
) (
  input  logic             clk,
  input  best_ctl_t        ctl,
  input  logic [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0] in_val,
  input  logic [AW-1:0]    in_idx,
  input  logic [KEY_W-1:0] item_key,
  output logic [KEY_W-1:0] best_key,
  output logic [VAL_W-1:0] best_val,
  output logic [AW-1:0]    best_idx,
  output logic             item_lt
);

  logic [KEY_W-1:0] best_key_r;
  logic [VAL_W-1:0] best_val_r;
  logic [AW-1:0]    best_idx_r;

  // strict greater keeps the earlier (lower index) child on ties
  always_ff @(posedge clk) begin
    if (ctl.upd && (ctl.load || (in_key > best_key_r))) begin
      best_key_r <= in_key;
      best_val_r <= in_val;
      best_idx_r <= in_idx;
    end
  end

  assign best_key = best_key_r;
  assign best_val = best_val_r;
  assign best_idx = best_idx_r;
  assign item_lt  = item_key < best_key_r;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the 4-ary top-k heap: stream driver, result monitor, scoreboard.
module tb_top;
  import qhtk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One input beat, packed so that {1'b0, cmd} is exactly the in_tdata layout
  // (operation lowest, then key, value, read_index).
  typedef struct packed {
    logic [RIDX_W-1:0] ridx;
    logic [VAL_W-1:0]  value;
    logic [KEY_W-1:0]  key;
    op_t               op;
  } heap_cmd_t;

  // One result beat, packed in out_tdata order (accepted lowest).
  typedef struct packed {
    logic [VAL_W-1:0] entry_value;
    logic [KEY_W-1:0] entry_key;
    logic [KEY_W-1:0] worst_key;
    logic [CNT_W-1:0] kept_count;
    logic             accepted;
  } heap_reply_t;

  localparam int SLOTS      = 64;
  localparam int FANOUT     = 4;
  localparam int LONG_HOLD  = 300;   // receiver back-pressure stretch, cycles
  localparam int TAIL_WAIT  = 60;    // quiet cycles after the last result

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // Stimulus and scoreboard queues
  heap_cmd_t        pending_cmds[$];
  heap_reply_t      expected_replies[$];
  logic [CNT_W-1:0] size_writes[$];

  // Shadow of the block: heap stores, fill level and the size register
  logic [KEY_W-1:0] kept_keys[SLOTS];
  logic [VAL_W-1:0] kept_vals[SLOTS];
  int               kept_fill = 0;
  logic [CNT_W-1:0] size_reg = 7'd64;

  // Idle shaping: calm turns off random gaps; hold requests are served by the receiver
  bit calm = 1'b0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  int errors = 0;
  int beats_checked = 0;
  int n_kept = 0, n_turned = 0, n_reads = 0, n_clears = 0, n_sizes = 0;

  always #5 clk = ~clk;

  quad_heap_topk_fill_and_replace u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Zero reads as one slot, anything above the store depth saturates.
  function automatic int clamp_size(logic [CNT_W-1:0] v);
    if (v < 1) return 1;
    if (v > SLOTS) return SLOTS;
    return int'(v);
  endfunction

  // Push slot s down the max-heap: larger child wins, ties to the lower index,
  // swap only while the parent is strictly smaller.
  function automatic void heap_sink(int s, int n);
    int first, big;
    logic [KEY_W-1:0] tk;
    logic [VAL_W-1:0] tv;
    bit done;
    done = 1'b0;
    while (!done && FANOUT * s + 1 < n) begin
      first = FANOUT * s + 1;
      big = first;
      for (int q = first + 1; q < first + FANOUT && q < n; q++)
        if (kept_keys[q] > kept_keys[big]) big = q;
      if (kept_keys[s] < kept_keys[big]) begin
        tk = kept_keys[s];
        tv = kept_vals[s];
        kept_keys[s] = kept_keys[big];
        kept_vals[s] = kept_vals[big];
        kept_keys[big] = tk;
        kept_vals[big] = tv;
        s = big;
      end else begin
        done = 1'b1;
      end
    end
  endfunction

  // Apply one accepted beat to the shadow heap and return the result it must produce.
  function automatic heap_reply_t predict_reply(heap_cmd_t c);
    heap_reply_t r;
    int n, kept, p;
    n = clamp_size(size_reg);
    r = '0;
    if (c.op == OP_INSERT) begin
      if (kept_fill < n) begin
        // filling: next free slot counted back from the end
        p = n - 1 - kept_fill;
        kept_keys[p] = c.key;
        kept_vals[p] = c.value;
        heap_sink(p, n);
        kept_fill++;
        r.accepted = 1'b1;
      end else if (c.key < kept_keys[0]) begin
        // full: strictly smaller key evicts the root
        kept_keys[0] = c.key;
        kept_vals[0] = c.value;
        heap_sink(0, n);
        r.accepted = 1'b1;
      end
      if (r.accepted) n_kept++;
      else n_turned++;
    end else if (c.op == OP_CLEAR) begin
      kept_fill = 0;   // stores keep their contents
      n_clears++;
    end else if (c.op == OP_READ) begin
      n_reads++;
    end
    kept = (kept_fill < n) ? kept_fill : n;
    r.kept_count = CNT_W'(kept);
    // only filled slots (n-kept .. n-1) read back, anything else is zero
    if (c.op == OP_READ && int'(c.ridx) < n && int'(c.ridx) >= n - kept) begin
      r.entry_key   = kept_keys[c.ridx];
      r.entry_value = kept_vals[c.ridx];
    end
    r.worst_key = (kept >= n) ? kept_keys[0] : '0;
    return r;
  endfunction

  task automatic check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Config channel: one heap_size beat per queued write
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_reg = cfg_data;
        n_sizes++;
      end
      if (!cfg_valid || cfg_ready) begin
        if (size_writes.size() != 0) begin
          cfg_valid <= 1'b1;
          cfg_data  <= size_writes.pop_front();
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Input driver: predict on every accepted beat, then offer the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_replies.push_back(predict_reply(heap_cmd_t'(in_tdata[IN_W-2:0])));
      if (!in_tvalid || in_tready) begin
        if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {1'b0, pending_cmds.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random ready, long holds on request, field-by-field compare
  always @(posedge clk) begin : result_mon
    heap_reply_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = heap_reply_t'(out_tdata[OUT_W-2:0]);
        beats_checked++;
        if (expected_replies.size() == 0) begin
          errors++;
          $display("%0t ns: result beat with nothing expected, expected none actual %h",
                   $time, got);
        end else begin
          want = expected_replies.pop_front();
          check_field("accepted", KEY_W'(want.accepted), KEY_W'(got.accepted));
          check_field("kept_count", KEY_W'(want.kept_count), KEY_W'(got.kept_count));
          check_field("worst_key", want.worst_key, got.worst_key);
          check_field("entry_key", want.entry_key, got.entry_key);
          check_field("entry_value", KEY_W'(want.entry_value), KEY_W'(got.entry_value));
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  task automatic put(op_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value,
                     logic [RIDX_W-1:0] ridx);
    heap_cmd_t c;
    c.op = op;
    c.key = key;
    c.value = value;
    c.ridx = ridx;
    pending_cmds.push_back(c);
  endtask

  // Random beat; keys lean on extremes and a narrow band so ties and evictions happen.
  function automatic heap_cmd_t rand_cmd(int n, bit with_clear);
    heap_cmd_t c;
    int r;
    r = $urandom_range(99);
    c.value = VAL_W'($urandom);
    c.ridx = $urandom_range(1) ? RIDX_W'($urandom_range(n - 1)) : RIDX_W'($urandom_range(63));
    case ($urandom_range(7))
      0:       c.key = '0;
      1:       c.key = '1;
      2, 3:    c.key = KEY_W'($urandom_range(63));
      default: c.key = $urandom;
    endcase
    if (with_clear && r < 4) c.op = OP_CLEAR;
    else if (r < 30)         c.op = OP_READ;
    else                     c.op = OP_INSERT;
    return c;
  endfunction

  // Mostly whole fill-then-replace runs after a clear, some unstructured noise.
  task automatic random_phase(int n, int total);
    int made, len;
    made = 0;
    while (made < total) begin
      if ($urandom_range(9) < 8) begin
        len = n + $urandom_range(1, 2 * n + 8);
        put(OP_CLEAR, $urandom, VAL_W'($urandom), RIDX_W'($urandom));
        for (int i = 0; i < len; i++) pending_cmds.push_back(rand_cmd(n, 1'b0));
        made += len + 1;
      end else begin
        for (int i = 0; i < 12; i++) pending_cmds.push_back(rand_cmd(n, 1'b1));
        made += 12;
      end
    end
  endtask

  task automatic write_size(logic [CNT_W-1:0] v);
    size_writes.push_back(v);
    do @(negedge clk); while (size_writes.size() != 0 || cfg_valid);
  endtask

  // Sender stops until every beat is in and every result is back
  task automatic drain();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_tvalid || expected_replies.size() != 0);
  endtask

  initial begin : stimulus
    int sched[12] = '{64, 1, 0, 127, 2, 5, 16, 21, 64, 3, -1, 64};
    logic [CNT_W-1:0] sz;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset size 64: empty reads, extreme fields, clear
    put(OP_READ,   '0, '0, 6'd63);
    put(OP_INSERT, '1, '1, '0);
    put(OP_INSERT, '0, '0, '1);
    put(OP_READ,   '0, '0, 6'd63);
    put(OP_READ,   '0, '0, 6'd62);
    put(OP_READ,   '0, '0, 6'd0);    // unfilled slot
    put(OP_READ,   '0, '0, 6'd61);
    put(OP_CLEAR,  '1, '1, '1);
    put(OP_READ,   '0, '0, 6'd63);   // cleared heap reads zero
    drain();

    // Directed, size 4: fill, tie on children, equal and larger keys turned away
    write_size(7'd4);
    put(OP_CLEAR,  '0, '0, '0);
    put(OP_INSERT, 32'd10, 31'd1, '0);
    put(OP_INSERT, 32'd20, 31'd2, '0);
    put(OP_INSERT, 32'd20, 31'd3, '0);
    put(OP_INSERT, 32'd5,  31'd4, '0);   // sift at root, tie goes to lower child
    put(OP_INSERT, 32'd20, 31'd5, '0);   // equal to root: rejected
    put(OP_INSERT, 32'd30, 31'd6, '0);
    put(OP_INSERT, 32'd7,  31'd7, '0);   // evicts root
    put(OP_INSERT, '0,     '1,    '0);
    for (int i = 0; i < 5; i++) put(OP_READ, '0, '0, RIDX_W'(i));   // slot 4 is past the size
    put(OP_READ,   '0, '0, 6'd63);
    put(OP_INSERT, '1, '0, '0);
    drain();

    // Random phases; each size change is followed by a clear before any insert
    foreach (sched[k]) begin
      sz = (sched[k] < 0) ? CNT_W'($urandom_range(1, 64)) : CNT_W'(sched[k]);
      write_size(sz);
      put(OP_CLEAR, '0, '0, '0);
      calm = (k == 0);
      if (k == 7) hold_requests++;
      random_phase(clamp_size(sz), 110);
      drain();
    end
    calm = 1'b0;

    repeat (TAIL_WAIT) @(negedge clk);
    if (expected_replies.size() != 0) errors++;
    $display("Checked %0d result beats over %0d heap_size writes (0, 1, 127 and 64 among them).",
             beats_checked, n_sizes);
    $display("Inserts kept %0d, turned away %0d; reads %0d; clears %0d.",
             n_kept, n_turned, n_reads, n_clears);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
